// ----- design/i2cm_pkg.sv -----
// i2cm_pkg: shared types and constants for the i2c master transaction engine
// no dependencies
`default_nettype none
package i2cm_pkg;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd50;

  // opcodes
  localparam logic [2:0] OP_WRITE_REG  = 3'd0;
  localparam logic [2:0] OP_READ_STOP  = 3'd1;
  localparam logic [2:0] OP_READ_RSTRT = 3'd2;
  localparam logic [2:0] OP_TRANSMIT   = 3'd3;
  localparam logic [2:0] OP_RECEIVE    = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BUS_BUSY = 2'd1;
  localparam logic [1:0] STAT_ADDR_NAK = 2'd2;

  // which byte the current ack slot belongs to
  typedef enum logic [1:0] {
    STG_ADDR  = 2'd0,
    STG_REG   = 2'd1,
    STG_DATA  = 2'd2,
    STG_RADDR = 2'd3
  } stage_e;

  typedef enum logic [15:0] {
    PH_IDLE     = 16'h0001,
    PH_START    = 16'h0002,
    PH_TX_LO    = 16'h0004,
    PH_TX_HI    = 16'h0008,
    PH_ACK_LO   = 16'h0010,
    PH_ACK_HI   = 16'h0020,
    PH_WR_WAIT  = 16'h0040,
    PH_RX_LO    = 16'h0080,
    PH_RX_HI    = 16'h0100,
    PH_RACK_LO  = 16'h0200,
    PH_RACK_HI  = 16'h0400,
    PH_RS_LO    = 16'h0800,
    PH_RS_HI    = 16'h1000,
    PH_STOP_LO  = 16'h2000,
    PH_STOP_HI  = 16'h4000,
    PH_STOP_END = 16'h8000
  } phase_e;

  // one tick beat
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] slave_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] wr_data;
    logic       wr_data_valid;
    logic       sda_in;
  } tick_t;

  // one result beat
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       data_request;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       done_res;
    logic [1:0] status;
  } res_t;

endpackage
`default_nettype wire

// ----- design/i2c_master_transaction_engine.sv -----
// i2c_master_transaction_engine: tick-driven 7-bit i2c master, top level
// a tick beat passes through the tick queue and then the output register on its way to its result beat
// throughput: one tick beat per cycle while the result beat is not stalled, set by the single-step phase sequencer
// a two-entry tick queue and an output register decouple input and output stalls
// reset: asynchronous active low, returns to idle with ack timeout 50
// depends on i2cm_pkg, i2cm_tick_fifo, i2cm_engine
`default_nettype none
module i2c_master_transaction_engine (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       cmd_valid_i,
  input  wire logic [2:0] opcode_i,
  input  wire logic [7:0] slave_addr_i,
  input  wire logic [7:0] reg_addr_i,
  input  wire logic [7:0] byte_count_i,
  input  wire logic [7:0] wr_data_i,
  input  wire logic       wr_data_valid_i,
  input  wire logic       sda_in_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            scl_out_o,
  output logic            sda_out_o,
  output logic            busy_res_o,
  output logic            data_request_o,
  output logic [7:0]      rd_data_o,
  output logic            rd_valid_o,
  output logic            done_res_o,
  output logic [1:0]      status_o
);

  i2cm_pkg::tick_t tick_in, tick_q;
  i2cm_pkg::res_t  res;
  logic            full, tick_valid, pop;

  // pack incoming beat
  assign tick_in.cmd_valid     = cmd_valid_i;
  assign tick_in.opcode        = opcode_i;
  assign tick_in.slave_addr    = slave_addr_i;
  assign tick_in.reg_addr      = reg_addr_i;
  assign tick_in.byte_count    = byte_count_i;
  assign tick_in.wr_data       = wr_data_i;
  assign tick_in.wr_data_valid = wr_data_valid_i;
  assign tick_in.sda_in        = sda_in_i;

  assign in_stall_o = full;

  i2cm_tick_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !full),
    .push_data_i (tick_in),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (tick_valid),
    .pop_data_o  (tick_q)
  );

  i2cm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .tick_valid_i (tick_valid),
    .tick_i       (tick_q),
    .tick_pop_o   (pop),
    .res_valid_o  (out_valid_o),
    .res_stall_i  (out_stall_i),
    .res_o        (res)
  );

  // unpack result beat
  assign scl_out_o      = res.scl_out;
  assign sda_out_o      = res.sda_out;
  assign busy_res_o     = res.busy_res;
  assign data_request_o = res.data_request;
  assign rd_data_o      = res.rd_data;
  assign rd_valid_o     = res.rd_valid;
  assign done_res_o     = res.done_res;
  assign status_o       = res.status;

endmodule
`default_nettype wire

// ----- design/i2cm_tick_fifo.sv -----
// i2cm_tick_fifo: two-entry queue of tick beats between front and engine
// depends on i2cm_pkg
`default_nettype none
module i2cm_tick_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire i2cm_pkg::tick_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output i2cm_pkg::tick_t     pop_data_o
);

  i2cm_pkg::tick_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;

  assign full_o     = count_q[1];
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      count_q <= count_q + 2'd1;
      else if (!push_i && pop_i) count_q <= count_q - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ----- design/i2cm_engine.sv -----
// i2cm_engine: bus sequencer, one phase step per tick beat, with output register
// depends on i2cm_pkg
`default_nettype none
module i2cm_engine (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [7:0]      cfg_wdata_i,
  input  wire logic            tick_valid_i,
  input  wire i2cm_pkg::tick_t tick_i,
  output logic                 tick_pop_o,
  output logic                 res_valid_o,
  input  wire logic            res_stall_i,
  output i2cm_pkg::res_t       res_o
);

  i2cm_pkg::phase_e st_q, st_d;
  i2cm_pkg::stage_e stg_q, stg_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] left_q, left_d;
  logic [7:0] wait_q, wait_d;
  logic [2:0] op_q, op_d;
  logic [7:0] slave_q, slave_d;
  logic [7:0] reg_q, reg_d;
  logic [1:0] end_q, end_d;
  logic       rs_q, rs_d;
  logic [7:0] tmo_q;
  logic       out_valid_q;
  i2cm_pkg::res_t res_q, res_d;
  logic       fire;
  logic       ack_ok;
  logic       ack_done;

  assign fire        = tick_valid_i && (!out_valid_q || !res_stall_i);
  assign tick_pop_o  = fire;
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  // next phase and result for the current tick
  always_comb begin
    st_d = st_q; stg_d = stg_q; bit_d = bit_q; shift_d = shift_q;
    left_d = left_q; wait_d = wait_q; op_d = op_q; slave_d = slave_q;
    reg_d = reg_q; end_d = end_q; rs_d = rs_q;
    res_d = '0;
    res_d.scl_out = 1'b1;
    res_d.sda_out = 1'b1;
    ack_ok   = !tick_i.sda_in;
    ack_done = ack_ok || (wait_q >= tmo_q);
    case (st_q)
      i2cm_pkg::PH_IDLE: begin
        if (tick_i.cmd_valid && tick_i.opcode <= i2cm_pkg::OP_RECEIVE) begin
          if (!tick_i.sda_in) begin
            res_d.done_res = 1'b1;
            res_d.status   = i2cm_pkg::STAT_BUS_BUSY;
          end else begin
            op_d = tick_i.opcode; slave_d = tick_i.slave_addr;
            reg_d = tick_i.reg_addr; left_d = tick_i.byte_count;
            stg_d = i2cm_pkg::STG_ADDR; end_d = i2cm_pkg::STAT_OK; rs_d = 1'b0;
            st_d = i2cm_pkg::PH_START;
          end
        end
      end
      i2cm_pkg::PH_START: begin
        res_d.sda_out = 1'b0;
        bit_d = 4'd0;
        st_d  = i2cm_pkg::PH_TX_LO;
        if (stg_q == i2cm_pkg::STG_ADDR) begin
          shift_d = slave_q;
        end else begin
          shift_d = slave_q + 8'd1;
          stg_d   = i2cm_pkg::STG_RADDR;
        end
      end
      i2cm_pkg::PH_TX_LO: begin
        res_d.scl_out = 1'b0;
        res_d.sda_out = shift_q[7];
        st_d = i2cm_pkg::PH_TX_HI;
      end
      i2cm_pkg::PH_TX_HI: begin
        res_d.sda_out = shift_q[7];
        shift_d = {shift_q[6:0], 1'b0};
        bit_d   = bit_q + 4'd1;
        st_d    = (bit_q >= 4'd7) ? i2cm_pkg::PH_ACK_LO : i2cm_pkg::PH_TX_LO;
      end
      i2cm_pkg::PH_ACK_LO: begin
        res_d.scl_out = 1'b0;
        wait_d = 8'd0;
        st_d   = i2cm_pkg::PH_ACK_HI;
      end
      i2cm_pkg::PH_ACK_HI: begin
        if (!ack_done) begin
          wait_d = wait_q + 8'd1;
        end else begin
          case (stg_q)
            i2cm_pkg::STG_ADDR: begin
              if (!ack_ok) begin
                end_d = i2cm_pkg::STAT_ADDR_NAK; st_d = i2cm_pkg::PH_STOP_LO;
              end else if (op_q <= i2cm_pkg::OP_READ_RSTRT) begin
                shift_d = reg_q; bit_d = 4'd0; stg_d = i2cm_pkg::STG_REG;
                st_d = i2cm_pkg::PH_TX_LO;
              end else if (op_q == i2cm_pkg::OP_TRANSMIT) begin
                if (left_q == 8'd0) begin
                  end_d = i2cm_pkg::STAT_OK; st_d = i2cm_pkg::PH_STOP_LO;
                end else begin
                  st_d = i2cm_pkg::PH_WR_WAIT;
                end
              end else if (left_q == 8'd0) begin
                end_d = i2cm_pkg::STAT_OK; st_d = i2cm_pkg::PH_STOP_LO;
              end else begin
                shift_d = 8'd0; bit_d = 4'd0; st_d = i2cm_pkg::PH_RX_LO;
              end
            end
            i2cm_pkg::STG_REG: begin
              if (op_q == i2cm_pkg::OP_WRITE_REG) begin
                if (left_q == 8'd0) begin
                  end_d = i2cm_pkg::STAT_OK; st_d = i2cm_pkg::PH_STOP_LO;
                end else begin
                  st_d = i2cm_pkg::PH_WR_WAIT;
                end
              end else if (op_q == i2cm_pkg::OP_READ_STOP) begin
                rs_d = 1'b1; end_d = i2cm_pkg::STAT_OK; st_d = i2cm_pkg::PH_STOP_LO;
              end else begin
                st_d = i2cm_pkg::PH_RS_LO;
              end
            end
            i2cm_pkg::STG_DATA: begin
              if (left_q == 8'd0) begin
                end_d = i2cm_pkg::STAT_OK; st_d = i2cm_pkg::PH_STOP_LO;
              end else begin
                st_d = i2cm_pkg::PH_WR_WAIT;
              end
            end
            default: begin
              if (!ack_ok) begin
                end_d = i2cm_pkg::STAT_ADDR_NAK; st_d = i2cm_pkg::PH_STOP_LO;
              end else if (left_q == 8'd0) begin
                end_d = i2cm_pkg::STAT_OK; st_d = i2cm_pkg::PH_STOP_LO;
              end else begin
                shift_d = 8'd0; bit_d = 4'd0; st_d = i2cm_pkg::PH_RX_LO;
              end
            end
          endcase
        end
      end
      i2cm_pkg::PH_WR_WAIT: begin
        res_d.scl_out = 1'b0;
        res_d.data_request = 1'b1;
        if (tick_i.wr_data_valid) begin
          left_d = left_q - 8'd1;
          shift_d = tick_i.wr_data; bit_d = 4'd0;
          stg_d = i2cm_pkg::STG_DATA; st_d = i2cm_pkg::PH_TX_LO;
        end
      end
      i2cm_pkg::PH_RX_LO: begin
        res_d.scl_out = 1'b0;
        st_d = i2cm_pkg::PH_RX_HI;
      end
      i2cm_pkg::PH_RX_HI: begin
        shift_d = {shift_q[6:0], tick_i.sda_in};
        bit_d   = bit_q + 4'd1;
        if (bit_q >= 4'd7) begin
          res_d.rd_data  = {shift_q[6:0], tick_i.sda_in};
          res_d.rd_valid = 1'b1;
          left_d = left_q - 8'd1;
          st_d   = i2cm_pkg::PH_RACK_LO;
        end else begin
          st_d = i2cm_pkg::PH_RX_LO;
        end
      end
      i2cm_pkg::PH_RACK_LO: begin
        res_d.scl_out = 1'b0;
        res_d.sda_out = (left_q == 8'd0);
        st_d = i2cm_pkg::PH_RACK_HI;
      end
      i2cm_pkg::PH_RACK_HI: begin
        res_d.sda_out = (left_q == 8'd0);
        if (left_q == 8'd0) begin
          end_d = i2cm_pkg::STAT_OK; st_d = i2cm_pkg::PH_STOP_LO;
        end else begin
          shift_d = 8'd0; bit_d = 4'd0; st_d = i2cm_pkg::PH_RX_LO;
        end
      end
      i2cm_pkg::PH_RS_LO: begin
        res_d.scl_out = 1'b0;
        st_d = i2cm_pkg::PH_RS_HI;
      end
      i2cm_pkg::PH_RS_HI: begin
        st_d = i2cm_pkg::PH_START;
      end
      i2cm_pkg::PH_STOP_LO: begin
        res_d.scl_out = 1'b0;
        res_d.sda_out = 1'b0;
        st_d = i2cm_pkg::PH_STOP_HI;
      end
      i2cm_pkg::PH_STOP_HI: begin
        res_d.sda_out = 1'b0;
        st_d = i2cm_pkg::PH_STOP_END;
      end
      default: begin
        if (rs_q) begin
          rs_d = 1'b0;
          st_d = i2cm_pkg::PH_START;
        end else begin
          res_d.done_res = 1'b1;
          res_d.status   = end_q;
          st_d = i2cm_pkg::PH_IDLE;
        end
      end
    endcase
    res_d.busy_res = (st_d != i2cm_pkg::PH_IDLE);
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= i2cm_pkg::PH_IDLE; stg_q <= i2cm_pkg::STG_ADDR;
      bit_q <= 4'd0; shift_q <= 8'd0; left_q <= 8'd0; wait_q <= 8'd0;
      op_q <= 3'd0; slave_q <= 8'd0; reg_q <= 8'd0;
      end_q <= i2cm_pkg::STAT_OK; rs_q <= 1'b0;
    end else if (fire) begin
      st_q <= st_d; stg_q <= stg_d;
      bit_q <= bit_d; shift_q <= shift_d; left_q <= left_d; wait_q <= wait_d;
      op_q <= op_d; slave_q <= slave_d; reg_q <= reg_d;
      end_q <= end_d; rs_q <= rs_d;
    end
  end

  // timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      tmo_q <= cfg_wdata_i;
    end
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res_d;
  end

  // a received byte is always followed by its ack slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_d.rd_valid |=> st_q == i2cm_pkg::PH_RACK_LO)
    else $error("rd_valid not followed by ack slot");

  // a finished transaction leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_d.done_res |=> st_q == i2cm_pkg::PH_IDLE)
    else $error("done without return to idle");

  // no tick beat, no phase change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(st_q))
    else $error("phase moved without a tick");

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// tb: self-checking testbench for the tick-driven i2c master transaction engine
// predicts each result beat from the tick beat it follows; depends on i2cm_pkg and the rtl
`timescale 1ns / 1ps
module tb;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [7:0]      cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  i2cm_pkg::tick_t tick_q = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  i2cm_pkg::res_t  res_w;

  i2c_master_transaction_engine u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_valid_i    (tick_q.cmd_valid),
    .opcode_i       (tick_q.opcode),
    .slave_addr_i   (tick_q.slave_addr),
    .reg_addr_i     (tick_q.reg_addr),
    .byte_count_i   (tick_q.byte_count),
    .wr_data_i      (tick_q.wr_data),
    .wr_data_valid_i(tick_q.wr_data_valid),
    .sda_in_i       (tick_q.sda_in),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .scl_out_o      (res_w.scl_out),
    .sda_out_o      (res_w.sda_out),
    .busy_res_o     (res_w.busy_res),
    .data_request_o (res_w.data_request),
    .rd_data_o      (res_w.rd_data),
    .rd_valid_o     (res_w.rd_valid),
    .done_res_o     (res_w.done_res),
    .status_o       (res_w.status)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // bus model state, mirrors the engine
  logic [7:0]       timeout_m;
  i2cm_pkg::phase_e ph_m;
  logic [3:0]       bit_m;
  logic [7:0]       shift_m, left_m, wait_m, slave_m, reg_m;
  logic [2:0]       op_m;
  i2cm_pkg::stage_e stage_m;
  logic [1:0]       end_stat_m;
  logic             restart_m;

  i2cm_pkg::res_t bus_expect_q[$];
  int     errors = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  bit     hold_req = 1'b0;

  // directed table
  typedef struct {
    i2cm_pkg::tick_t t;
    bit              typed;
    i2cm_pkg::res_t  r;
  } row_t;
  row_t           rows[$];
  bit             typed_pending = 1'b0;
  i2cm_pkg::res_t typed_res;

  function automatic void go_stop(input logic [1:0] st);
    end_stat_m = st;
    ph_m = i2cm_pkg::PH_STOP_LO;
  endfunction

  function automatic void send_byte(input logic [7:0] b, input i2cm_pkg::stage_e st);
    shift_m = b;
    bit_m = '0;
    stage_m = st;
    ph_m = i2cm_pkg::PH_TX_LO;
  endfunction

  function automatic void write_next();
    if (left_m == 0) go_stop(i2cm_pkg::STAT_OK);
    else ph_m = i2cm_pkg::PH_WR_WAIT;
  endfunction

  function automatic void read_next();
    if (left_m == 0) begin
      go_stop(i2cm_pkg::STAT_OK);
    end else begin
      shift_m = '0;
      bit_m = '0;
      ph_m = i2cm_pkg::PH_RX_LO;
    end
  endfunction

  function automatic void after_ack(input bit acked);
    case (stage_m)
      i2cm_pkg::STG_ADDR: begin
        if (!acked) go_stop(i2cm_pkg::STAT_ADDR_NAK);
        else if (op_m <= i2cm_pkg::OP_READ_RSTRT) send_byte(reg_m, i2cm_pkg::STG_REG);
        else if (op_m == i2cm_pkg::OP_TRANSMIT) write_next();
        else read_next();
      end
      i2cm_pkg::STG_REG: begin
        if (op_m == i2cm_pkg::OP_WRITE_REG) begin
          write_next();
        end else if (op_m == i2cm_pkg::OP_READ_STOP) begin
          restart_m = 1'b1;
          go_stop(i2cm_pkg::STAT_OK);
        end else begin
          ph_m = i2cm_pkg::PH_RS_LO;
        end
      end
      i2cm_pkg::STG_DATA: write_next();
      default: begin
        if (!acked) go_stop(i2cm_pkg::STAT_ADDR_NAK);
        else read_next();
      end
    endcase
  endfunction

  // one tick of the bus model
  function automatic i2cm_pkg::res_t bus_step(input i2cm_pkg::tick_t t);
    i2cm_pkg::res_t r;
    r = '0;
    r.scl_out = 1'b1;
    r.sda_out = 1'b1;
    case (ph_m)
      i2cm_pkg::PH_IDLE: begin
        if (t.cmd_valid && t.opcode <= i2cm_pkg::OP_RECEIVE) begin
          if (!t.sda_in) begin
            r.done_res = 1'b1;
            r.status = i2cm_pkg::STAT_BUS_BUSY;
          end else begin
            op_m = t.opcode;
            slave_m = t.slave_addr;
            reg_m = t.reg_addr;
            left_m = t.byte_count;
            stage_m = i2cm_pkg::STG_ADDR;
            end_stat_m = i2cm_pkg::STAT_OK;
            restart_m = 1'b0;
            ph_m = i2cm_pkg::PH_START;
          end
        end
      end
      i2cm_pkg::PH_START: begin
        r.sda_out = 1'b0;
        if (stage_m == i2cm_pkg::STG_ADDR) send_byte(slave_m, i2cm_pkg::STG_ADDR);
        else send_byte(slave_m + 8'd1, i2cm_pkg::STG_RADDR);
      end
      i2cm_pkg::PH_TX_LO: begin
        r.scl_out = 1'b0;
        r.sda_out = shift_m[7];
        ph_m = i2cm_pkg::PH_TX_HI;
      end
      i2cm_pkg::PH_TX_HI: begin
        r.sda_out = shift_m[7];
        shift_m = shift_m << 1;
        bit_m++;
        ph_m = (bit_m >= 8) ? i2cm_pkg::PH_ACK_LO : i2cm_pkg::PH_TX_LO;
      end
      i2cm_pkg::PH_ACK_LO: begin
        r.scl_out = 1'b0;
        wait_m = '0;
        ph_m = i2cm_pkg::PH_ACK_HI;
      end
      i2cm_pkg::PH_ACK_HI: begin
        if (!t.sda_in) after_ack(1'b1);
        else if (wait_m >= timeout_m) after_ack(1'b0);
        else wait_m++;
      end
      i2cm_pkg::PH_WR_WAIT: begin
        r.scl_out = 1'b0;
        r.data_request = 1'b1;
        if (t.wr_data_valid) begin
          left_m--;
          send_byte(t.wr_data, i2cm_pkg::STG_DATA);
        end
      end
      i2cm_pkg::PH_RX_LO: begin
        r.scl_out = 1'b0;
        ph_m = i2cm_pkg::PH_RX_HI;
      end
      i2cm_pkg::PH_RX_HI: begin
        shift_m = {shift_m[6:0], t.sda_in};
        bit_m++;
        if (bit_m >= 8) begin
          r.rd_data = shift_m;
          r.rd_valid = 1'b1;
          left_m--;
          ph_m = i2cm_pkg::PH_RACK_LO;
        end else begin
          ph_m = i2cm_pkg::PH_RX_LO;
        end
      end
      i2cm_pkg::PH_RACK_LO: begin
        r.scl_out = 1'b0;
        r.sda_out = (left_m == 0);
        ph_m = i2cm_pkg::PH_RACK_HI;
      end
      i2cm_pkg::PH_RACK_HI: begin
        r.sda_out = (left_m == 0);
        read_next();
      end
      i2cm_pkg::PH_RS_LO: begin
        r.scl_out = 1'b0;
        ph_m = i2cm_pkg::PH_RS_HI;
      end
      i2cm_pkg::PH_RS_HI: ph_m = i2cm_pkg::PH_START;
      i2cm_pkg::PH_STOP_LO: begin
        r.scl_out = 1'b0;
        r.sda_out = 1'b0;
        ph_m = i2cm_pkg::PH_STOP_HI;
      end
      i2cm_pkg::PH_STOP_HI: begin
        r.sda_out = 1'b0;
        ph_m = i2cm_pkg::PH_STOP_END;
      end
      default: begin
        if (restart_m) begin
          restart_m = 1'b0;
          ph_m = i2cm_pkg::PH_START;
        end else begin
          r.done_res = 1'b1;
          r.status = end_stat_m;
          ph_m = i2cm_pkg::PH_IDLE;
        end
      end
    endcase
    r.busy_res = (ph_m != i2cm_pkg::PH_IDLE);
    return r;
  endfunction

  // random tick shaped by where the transaction stands
  function automatic i2cm_pkg::tick_t rand_tick();
    i2cm_pkg::tick_t t;
    logic [63:0]     raw;
    raw = {$urandom, $urandom};
    t = raw[$bits(i2cm_pkg::tick_t)-1:0];
    t.opcode = ($urandom_range(15) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
    t.slave_addr = 8'($urandom_range(0, 254));
    if (ph_m == i2cm_pkg::PH_IDLE) begin
      t.cmd_valid = ($urandom_range(3) != 0);
      t.sda_in = ($urandom_range(9) != 0);
      t.byte_count = ($urandom_range(19) == 0) ? 8'($urandom_range(0, 12))
                                               : 8'($urandom_range(0, 3));
    end else if (ph_m == i2cm_pkg::PH_ACK_HI) begin
      t.sda_in = ($urandom_range(3) == 0);
    end
    return t;
  endfunction

  task automatic cmp_field(input string name, input int e, input int a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      errors++;
    end
  endtask

  // accept tick beats and check result beats
  always @(posedge clk_i) begin
    i2cm_pkg::res_t e;
    if (out_valid_o && !out_stall_i) begin
      if (bus_expect_q.size() == 0) begin
        $display("%0t: result beat with none expected, actual %h", $time, res_w);
        errors++;
      end else begin
        e = bus_expect_q.pop_front();
        cmp_field("scl_out", e.scl_out, res_w.scl_out);
        cmp_field("sda_out", e.sda_out, res_w.sda_out);
        cmp_field("busy_res", e.busy_res, res_w.busy_res);
        cmp_field("data_request", e.data_request, res_w.data_request);
        cmp_field("rd_data", e.rd_data, res_w.rd_data);
        cmp_field("rd_valid", e.rd_valid, res_w.rd_valid);
        cmp_field("done_res", e.done_res, res_w.done_res);
        cmp_field("status", e.status, res_w.status);
      end
    end
    if (in_valid_i && !in_stall_o) begin
      e = bus_step(tick_q);
      bus_expect_q.push_back(typed_pending ? typed_res : e);
    end
  end

  // receiver stalls, with one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (200) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic put_tick(input i2cm_pkg::tick_t t, input bit typed, input i2cm_pkg::res_t r,
                          input bit gen);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    if (gen) t = rand_tick();
    tick_q <= t;
    in_valid_i <= 1'b1;
    typed_pending = typed;
    typed_res = r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic add_row(input i2cm_pkg::tick_t t, input bit typed, input i2cm_pkg::res_t r);
    row_t w;
    w.t = t;
    w.typed = typed;
    w.r = r;
    rows.push_back(w);
  endtask

  task automatic drain_and_cfg(input logic [7:0] val);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (bus_expect_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    timeout_m = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // watchdog
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  // stimulus
  initial begin
    i2cm_pkg::res_t  idle_r, busy_r, ok_r, none;
    i2cm_pkg::tick_t t;
    logic [7:0] cfg_vals[4];
    int    i, p;
    none = '0;
    idle_r = '{scl_out: 1'b1, sda_out: 1'b1, default: '0};
    busy_r = idle_r;
    busy_r.done_res = 1'b1;
    busy_r.status = i2cm_pkg::STAT_BUS_BUSY;
    ok_r = idle_r;
    ok_r.done_res = 1'b1;
    ok_r.status = i2cm_pkg::STAT_OK;
    cfg_vals = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(2, 254))};

    timeout_m = i2cm_pkg::ACK_TIMEOUT_RST;
    ph_m = i2cm_pkg::PH_IDLE;
    bit_m = '0; shift_m = '0; left_m = '0; wait_m = '0;
    op_m = '0; slave_m = '0; reg_m = '0;
    stage_m = i2cm_pkg::STG_ADDR; end_stat_m = i2cm_pkg::STAT_OK; restart_m = 1'b0;

    // directed rows: idle, bus busy, undefined opcode, then a full zero-length transmit
    add_row('{cmd_valid: 1'b0, sda_in: 1'b1, default: '0}, 1'b1, idle_r);
    add_row('{cmd_valid: 1'b1, opcode: i2cm_pkg::OP_WRITE_REG, sda_in: 1'b0, default: '0},
            1'b1, busy_r);
    add_row('{cmd_valid: 1'b1, opcode: 3'd7, slave_addr: 8'hFE, sda_in: 1'b1,
              default: '1}, 1'b1, idle_r);
    add_row('{cmd_valid: 1'b1, opcode: i2cm_pkg::OP_TRANSMIT, slave_addr: 8'hFE,
              reg_addr: 8'hFF, byte_count: 8'd0, wr_data: 8'hFF, wr_data_valid: 1'b1,
              sda_in: 1'b1}, 1'b0, none);
    // start, address bits and ack-low with commands offered while busy
    for (i = 0; i < 18; i++) begin
      add_row('{cmd_valid: 1'b1, opcode: 3'(i % 5), slave_addr: 8'(i), reg_addr: 8'(i),
                byte_count: 8'd0, wr_data: 8'(i), wr_data_valid: 1'b0, sda_in: 1'b1},
              1'b0, none);
    end
    add_row('{sda_in: 1'b0, default: '0}, 1'b0, none);
    add_row('{sda_in: 1'b1, default: '0}, 1'b0, none);
    add_row('{sda_in: 1'b1, default: '0}, 1'b0, none);
    add_row('{sda_in: 1'b1, default: '0}, 1'b0, ok_r);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[k]) put_tick(rows[k].t, rows[k].typed, rows[k].r, 1'b0);

    // random phases with different idling, receiver stalls and ack timeouts
    for (p = 0; p < 4; p++) begin
      drain_and_cfg(cfg_vals[p]);
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      for (i = 0; i < 240; i++) begin
        if (p == 0 && i == 60) hold_req = 1'b1;
        put_tick(t, 1'b0, none, 1'b1);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    i = 0;
    while (bus_expect_q.size() != 0 && i < 100000) begin
      @(posedge clk_i);
      i++;
    end
    repeat (10) @(posedge clk_i);
    if (errors == 0 && bus_expect_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/i2cm_pkg.sv
design/i2cm_tick_fifo.sv
design/i2cm_engine.sv
design/i2c_master_transaction_engine.sv
tb/sv/tb.sv
